// File: rtl/svpf_pkg.sv
// svpf_pkg: constants, state and control types for the steer/velocity filter
// fixed-point constants are kept in Q30 (the yaw gain in Q20); some are rounded to the working format at elaboration
// no dependencies
`default_nettype none

package svpf_pkg;

  // field widths of the beats
  localparam int CODE_W        = 8;
  localparam int YAW_W         = 27;
  localparam int VEL_W         = 18;

  // working format default and shared multiplier size
  localparam int FRAC_BITS_DEF = 16;
  localparam int OPW           = 33;
  localparam int PRODW         = 2 * OPW;

  // filter constants, Q30 unless noted
  localparam longint Q30_STEER = 64'sd264198363;
  localparam longint Q30_COLL  = 64'sd8454665;
  localparam longint Q30_P7    = 64'sd751619277;
  localparam longint Q30_P3    = 64'sd322122547;
  localparam longint Q30_P2    = 64'sd214748365;
  localparam longint Q30_P6    = 64'sd644245094;
  localparam longint Q20_YAW   = 64'sd30039605;
  localparam int     YAW_SHIFT = 20;

  // round a positive Q30 constant to Q(f), half away from zero
  function automatic longint from_q30(longint k, int f);
    return (k + (longint'(1) <<< (29 - f))) >>> (30 - f);
  endfunction

  // sequencer steps, one item runs through all of them in order
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_STEER,
    ST_MUL_COLL,
    ST_MUL_OLD_STEER,
    ST_MUL_NEW_STEER,
    ST_SUM_STEER,
    ST_MUL_INTEG,
    ST_MUL_YAW,
    ST_ROUND_INTEG,
    ST_ROUND_YAW,
    ST_MUL_SQUARE,
    ST_MUL_OLD_VEL,
    ST_ROUND_SQUARE,
    ST_MUL_NEW_VEL,
    ST_SUM_VEL,
    ST_WRITE_VEL
  } state_t;

  // multiplier operand pairs
  typedef enum logic [3:0] {
    MS_NONE,
    MS_STEER,
    MS_COLL,
    MS_OLD_STEER,
    MS_NEW_STEER,
    MS_INTEG,
    MS_YAW,
    MS_SQUARE,
    MS_OLD_VEL,
    MS_NEW_VEL
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  // where the rounded accumulator goes
  typedef enum logic [2:0] {
    RD_NONE,
    RD_S0,
    RD_C,
    RD_FS,
    RD_R,
    RD_YAW,
    RD_U,
    RD_FV
  } rnd_dst_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    rnd_dst_t rnd_dst;
    logic     upd_integ;
    logic     upd_diff;
    logic     finish;
  } ctrl_t;

  // control word of each step
  function automatic ctrl_t decode(state_t st);
    ctrl_t c;
    c = '{mul_sel: MS_NONE, acc_op: ACC_HOLD, rnd_dst: RD_NONE,
          upd_integ: 1'b0, upd_diff: 1'b0, finish: 1'b0};
    unique case (st)
      ST_IDLE:          ;
      ST_MUL_STEER:     c.mul_sel = MS_STEER;
      ST_MUL_COLL: begin
        c.mul_sel = MS_COLL;
        c.acc_op  = ACC_LOAD;
      end
      ST_MUL_OLD_STEER: begin
        c.mul_sel = MS_OLD_STEER;
        c.acc_op  = ACC_LOAD;
        c.rnd_dst = RD_S0;
      end
      ST_MUL_NEW_STEER: begin
        c.mul_sel = MS_NEW_STEER;
        c.acc_op  = ACC_LOAD;
        c.rnd_dst = RD_C;
      end
      ST_SUM_STEER: begin
        c.acc_op    = ACC_ADD;
        c.upd_integ = 1'b1;
      end
      ST_MUL_INTEG: begin
        c.mul_sel = MS_INTEG;
        c.rnd_dst = RD_FS;
      end
      ST_MUL_YAW: begin
        c.mul_sel = MS_YAW;
        c.acc_op  = ACC_LOAD;
      end
      ST_ROUND_INTEG: begin
        c.acc_op  = ACC_LOAD;
        c.rnd_dst = RD_R;
      end
      ST_ROUND_YAW: begin
        c.rnd_dst  = RD_YAW;
        c.upd_diff = 1'b1;
      end
      ST_MUL_SQUARE:    c.mul_sel = MS_SQUARE;
      ST_MUL_OLD_VEL: begin
        c.mul_sel = MS_OLD_VEL;
        c.acc_op  = ACC_LOAD;
      end
      ST_ROUND_SQUARE: begin
        c.acc_op  = ACC_LOAD;
        c.rnd_dst = RD_U;
      end
      ST_MUL_NEW_VEL:   c.mul_sel = MS_NEW_VEL;
      ST_SUM_VEL:       c.acc_op = ACC_ADD;
      ST_WRITE_VEL: begin
        c.rnd_dst = RD_FV;
        c.finish  = 1'b1;
      end
      default:          ;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/svpf_in_if.sv
// svpf_in_if: input channel, one beat carries a steer code and a collision code
// depends on svpf_pkg for field widths
`default_nettype none

interface svpf_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [svpf_pkg::CODE_W-1:0]  steer_code;
  logic        [svpf_pkg::CODE_W-1:0]  collision_code;

  modport source (output valid, output steer_code, output collision_code, input ready);
  modport sink   (input valid, input steer_code, input collision_code, output ready);
endinterface

`default_nettype wire

// File: rtl/svpf_out_if.sv
// svpf_out_if: result channel, one beat carries the yaw-rate command and the velocity
// depends on svpf_pkg for field widths
`default_nettype none

interface svpf_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [svpf_pkg::YAW_W-1:0]  yaw_rate_cmd;
  logic        [svpf_pkg::VEL_W-1:0]  forward_velocity;

  modport source (output valid, output yaw_rate_cmd, output forward_velocity, input ready);
  modport sink   (input valid, input yaw_rate_cmd, input forward_velocity, output ready);
endinterface

`default_nettype wire

// File: rtl/steer_velocity_prediction_filter_core.sv
// steer_velocity_prediction_filter_core: a 15-step sequencer drives one shared 33x33
// signed multiplier, an accumulator and a rounding/saturation stage; a new input beat is
// taken only once the last item's result has gone to the output register.
// a finished result waits in an output register; the last step stalls only if it is full.
// synchronous active-high reset clears the filter state (steer, integral, velocity) to zero.
// depends on svpf_pkg, svpf_in_if, svpf_out_if
`default_nettype none

module steer_velocity_prediction_filter_core #(
  parameter int FRAC_BITS = svpf_pkg::FRAC_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  svpf_in_if.sink     sample,
  svpf_out_if.source  command
);

  localparam int OPW   = svpf_pkg::OPW;
  localparam int PW    = svpf_pkg::PRODW;
  localparam int CDW   = svpf_pkg::CODE_W;
  localparam int YW    = svpf_pkg::YAW_W;
  localparam int VW    = svpf_pkg::VEL_W;
  localparam int YSH   = svpf_pkg::YAW_SHIFT;
  localparam int QSH   = 30 - FRAC_BITS;
  localparam int SW    = FRAC_BITS + 7;   // dequantized steer, signed
  localparam int CW    = FRAC_BITS + 2;   // collision value and integral, unsigned
  localparam int RW    = FRAC_BITS + 1;   // integral share, unsigned
  localparam int DW    = FRAC_BITS + 3;   // 1 - m, signed
  localparam int UW    = FRAC_BITS + 2;   // (1 - m)^2, unsigned
  localparam int FSW   = 32;

  localparam longint ONE_L = longint'(1) <<< FRAC_BITS;

  // multiplier constants in Q(FRAC_BITS) or their native scale
  localparam logic signed [OPW-1:0] K_STEER = OPW'(svpf_pkg::Q30_STEER);
  localparam logic signed [OPW-1:0] K_COLL  = OPW'(svpf_pkg::Q30_COLL);
  localparam logic signed [OPW-1:0] K_YAW   = OPW'(svpf_pkg::Q20_YAW);
  localparam logic signed [OPW-1:0] K_P2    =
    OPW'(svpf_pkg::from_q30(svpf_pkg::Q30_P2, FRAC_BITS));
  localparam logic signed [OPW-1:0] W_NEW7  =
    OPW'(svpf_pkg::from_q30(svpf_pkg::Q30_P7, FRAC_BITS));
  localparam logic signed [OPW-1:0] W_OLD7  =
    OPW'(ONE_L - svpf_pkg::from_q30(svpf_pkg::Q30_P7, FRAC_BITS));
  localparam logic signed [OPW-1:0] W_NEW6  =
    OPW'(svpf_pkg::from_q30(svpf_pkg::Q30_P6, FRAC_BITS));
  localparam logic signed [OPW-1:0] W_OLD6  =
    OPW'(ONE_L - svpf_pkg::from_q30(svpf_pkg::Q30_P6, FRAC_BITS));
  localparam logic signed [CW+1:0]  K_P3    =
    (CW+2)'(svpf_pkg::from_q30(svpf_pkg::Q30_P3, FRAC_BITS));

  localparam logic        [CW-1:0]  INTEG_MAX = CW'(longint'(3) <<< FRAC_BITS);
  localparam logic signed [DW-1:0]  ONE_D     = DW'(ONE_L);

  // rounding offsets
  localparam logic signed [PW-1:0]  HALF_Q = PW'(longint'(1) <<< (QSH - 1));
  localparam logic signed [PW-1:0]  HALF_F = PW'(longint'(1) <<< (FRAC_BITS - 1));
  localparam logic signed [PW-1:0]  HALF_Y = PW'(longint'(1) <<< (YSH - 1));

  // saturation bounds
  localparam logic signed [PW-1:0]  FS_MAX  = PW'((longint'(1) <<< (FSW - 1)) - 1);
  localparam logic signed [PW-1:0]  FS_MIN  = PW'(-(longint'(1) <<< (FSW - 1)));
  localparam logic signed [PW-1:0]  YAW_MAX = PW'((longint'(1) <<< (YW - 1)) - 1);
  localparam logic signed [PW-1:0]  YAW_MIN = PW'(-(longint'(1) <<< (YW - 1)));
  localparam logic signed [PW-1:0]  VEL_MAX = PW'((longint'(1) <<< VW) - 1);

  svpf_pkg::state_t state, state_next;
  svpf_pkg::ctrl_t  ctrl;

  // captured codes and intermediate values
  logic signed [CDW-1:0] code_r;
  logic        [CDW-1:0] ccode_r;
  logic signed [PW-1:0]  prod;
  logic signed [PW-1:0]  acc;
  logic signed [SW-1:0]  s0;
  logic        [CW-1:0]  c;
  logic        [RW-1:0]  r;
  logic signed [DW-1:0]  d;
  logic        [UW-1:0]  u;
  logic signed [YW-1:0]  yaw;

  // filter state
  logic signed [FSW-1:0] fs;
  logic        [CW-1:0]  ci;
  logic        [VW-1:0]  fv;

  // output register
  logic                  out_valid;
  logic signed [YW-1:0]  yaw_out;
  logic        [VW-1:0]  vel_out;

  logic                  advance;
  logic signed [OPW-1:0] opa, opb;
  logic signed [PW-1:0]  mul_out;
  logic signed [PW-1:0]  rnd_half;
  logic signed [PW-1:0]  rnd_sum;
  logic signed [PW-1:0]  rnd_val;
  logic signed [FSW-1:0] fs_sat;
  logic signed [YW-1:0]  yaw_sat;
  logic        [VW-1:0]  fv_sat;
  logic signed [CW+1:0]  integ_sum;
  logic        [CW-1:0]  integ_next;

  assign ctrl    = svpf_pkg::decode(state);
  assign advance = !(ctrl.finish && out_valid && !command.ready);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      svpf_pkg::ST_IDLE:          if (sample.valid) state_next = svpf_pkg::ST_MUL_STEER;
      svpf_pkg::ST_MUL_STEER:     state_next = svpf_pkg::ST_MUL_COLL;
      svpf_pkg::ST_MUL_COLL:      state_next = svpf_pkg::ST_MUL_OLD_STEER;
      svpf_pkg::ST_MUL_OLD_STEER: state_next = svpf_pkg::ST_MUL_NEW_STEER;
      svpf_pkg::ST_MUL_NEW_STEER: state_next = svpf_pkg::ST_SUM_STEER;
      svpf_pkg::ST_SUM_STEER:     state_next = svpf_pkg::ST_MUL_INTEG;
      svpf_pkg::ST_MUL_INTEG:     state_next = svpf_pkg::ST_MUL_YAW;
      svpf_pkg::ST_MUL_YAW:       state_next = svpf_pkg::ST_ROUND_INTEG;
      svpf_pkg::ST_ROUND_INTEG:   state_next = svpf_pkg::ST_ROUND_YAW;
      svpf_pkg::ST_ROUND_YAW:     state_next = svpf_pkg::ST_MUL_SQUARE;
      svpf_pkg::ST_MUL_SQUARE:    state_next = svpf_pkg::ST_MUL_OLD_VEL;
      svpf_pkg::ST_MUL_OLD_VEL:   state_next = svpf_pkg::ST_ROUND_SQUARE;
      svpf_pkg::ST_ROUND_SQUARE:  state_next = svpf_pkg::ST_MUL_NEW_VEL;
      svpf_pkg::ST_MUL_NEW_VEL:   state_next = svpf_pkg::ST_SUM_VEL;
      svpf_pkg::ST_SUM_VEL:       state_next = svpf_pkg::ST_WRITE_VEL;
      svpf_pkg::ST_WRITE_VEL:     if (advance) state_next = svpf_pkg::ST_IDLE;
      default:                    state_next = svpf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= svpf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // handshake outputs
  assign sample.ready             = (state == svpf_pkg::ST_IDLE) && !rst;
  assign command.valid            = out_valid;
  assign command.yaw_rate_cmd     = yaw_out;
  assign command.forward_velocity = vel_out;

  // multiplier operand select
  always_comb begin
    opa = '0;
    opb = '0;
    unique case (ctrl.mul_sel)
      svpf_pkg::MS_NONE:      ;
      svpf_pkg::MS_STEER:     begin opa = OPW'(code_r);  opb = K_STEER; end
      svpf_pkg::MS_COLL:      begin opa = OPW'(ccode_r); opb = K_COLL;  end
      svpf_pkg::MS_OLD_STEER: begin opa = OPW'(fs);      opb = W_OLD7;  end
      svpf_pkg::MS_NEW_STEER: begin opa = OPW'(s0);      opb = W_NEW7;  end
      svpf_pkg::MS_INTEG:     begin opa = OPW'(ci);      opb = K_P2;    end
      svpf_pkg::MS_YAW:       begin opa = OPW'(fs);      opb = K_YAW;   end
      svpf_pkg::MS_SQUARE:    begin opa = OPW'(d);       opb = OPW'(d); end
      svpf_pkg::MS_OLD_VEL:   begin opa = OPW'(fv);      opb = W_OLD6;  end
      svpf_pkg::MS_NEW_VEL:   begin opa = OPW'(u);       opb = W_NEW6;  end
      default:                ;
    endcase
  end

  assign mul_out = opa * opb;

  // round half away from zero: add half, less one when negative, then shift
  always_comb begin
    rnd_half = HALF_F;
    unique case (ctrl.rnd_dst)
      svpf_pkg::RD_S0, svpf_pkg::RD_C: rnd_half = HALF_Q;
      svpf_pkg::RD_YAW:                rnd_half = HALF_Y;
      svpf_pkg::RD_NONE, svpf_pkg::RD_FS, svpf_pkg::RD_R,
      svpf_pkg::RD_U, svpf_pkg::RD_FV: rnd_half = HALF_F;
      default:                         rnd_half = HALF_F;
    endcase
    rnd_sum = acc + rnd_half - $signed({{(PW-1){1'b0}}, acc[PW-1]});
    rnd_val = rnd_sum >>> FRAC_BITS;
    unique case (ctrl.rnd_dst)
      svpf_pkg::RD_S0, svpf_pkg::RD_C: rnd_val = rnd_sum >>> QSH;
      svpf_pkg::RD_YAW:                rnd_val = rnd_sum >>> YSH;
      svpf_pkg::RD_NONE, svpf_pkg::RD_FS, svpf_pkg::RD_R,
      svpf_pkg::RD_U, svpf_pkg::RD_FV: rnd_val = rnd_sum >>> FRAC_BITS;
      default:                         rnd_val = rnd_sum >>> FRAC_BITS;
    endcase
  end

  // saturation of the rounded value
  always_comb begin
    if (rnd_val > FS_MAX) begin
      fs_sat = FS_MAX[FSW-1:0];
    end else if (rnd_val < FS_MIN) begin
      fs_sat = FS_MIN[FSW-1:0];
    end else begin
      fs_sat = rnd_val[FSW-1:0];
    end
    if (rnd_val > YAW_MAX) begin
      yaw_sat = YAW_MAX[YW-1:0];
    end else if (rnd_val < YAW_MIN) begin
      yaw_sat = YAW_MIN[YW-1:0];
    end else begin
      yaw_sat = rnd_val[YW-1:0];
    end
    if (rnd_val < 0) begin
      fv_sat = '0;
    end else if (rnd_val > VEL_MAX) begin
      fv_sat = VEL_MAX[VW-1:0];
    end else begin
      fv_sat = rnd_val[VW-1:0];
    end
  end

  // collision integral, clamped to 0..3.0
  always_comb begin
    integ_sum = $signed((CW+2)'(ci)) + $signed((CW+2)'(c)) - K_P3;
    if (integ_sum < 0) begin
      integ_next = '0;
    end else if (integ_sum > $signed((CW+2)'(INTEG_MAX))) begin
      integ_next = INTEG_MAX;
    end else begin
      integ_next = integ_sum[CW-1:0];
    end
  end

  // filter state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      fs        <= '0;
      ci        <= '0;
      fv        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctrl.rnd_dst == svpf_pkg::RD_FS) fs <= fs_sat;
      if (ctrl.upd_integ) ci <= integ_next;
      if (ctrl.finish && advance) begin
        fv        <= fv_sat;
        out_valid <= 1'b1;
      end else if (command.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      code_r  <= sample.steer_code;
      ccode_r <= sample.collision_code;
    end
    if (ctrl.mul_sel != svpf_pkg::MS_NONE) prod <= mul_out;
    unique case (ctrl.acc_op)
      svpf_pkg::ACC_HOLD: ;
      svpf_pkg::ACC_LOAD: acc <= prod;
      svpf_pkg::ACC_ADD:  acc <= acc + prod;
      default:            ;
    endcase
    unique case (ctrl.rnd_dst)
      svpf_pkg::RD_NONE: ;
      svpf_pkg::RD_S0:   s0  <= rnd_val[SW-1:0];
      svpf_pkg::RD_C:    c   <= rnd_val[CW-1:0];
      svpf_pkg::RD_FS:   ;
      svpf_pkg::RD_R:    r   <= rnd_val[RW-1:0];
      svpf_pkg::RD_YAW:  yaw <= yaw_sat;
      svpf_pkg::RD_U:    u   <= rnd_val[UW-1:0];
      svpf_pkg::RD_FV:   ;
      default:           ;
    endcase
    if (ctrl.upd_diff) d <= ONE_D - $signed(DW'(c)) - $signed(DW'(r));
    if (ctrl.finish && advance) begin
      yaw_out <= yaw;
      vel_out <= fv_sat;
    end
  end

  // integral stays within its clamp range
  a_integ_bound: assert property (@(posedge clk) disable iff (rst)
    ci <= INTEG_MAX)
    else $error("collision integral above 3.0");

  // an accepted beat starts the sequence
  a_start: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> state == svpf_pkg::ST_MUL_STEER)
    else $error("sequencer did not start after accepted beat");

  // a result appears only out of the last step
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(command.valid) |-> $past(state) == svpf_pkg::ST_WRITE_VEL)
    else $error("result raised outside the last step");

  // the pending velocity is the stored filter state
  a_vel_match: assert property (@(posedge clk) disable iff (rst)
    command.valid |-> command.forward_velocity == fv)
    else $error("pending velocity differs from filter state");

endmodule

`default_nettype wire
